/* sv/ptl_pkg.sv */
// ----------------------------------------------------------------------------
// ptl_pkg
// Shared constants and types for the planar tile to linear pixel converter.
// ----------------------------------------------------------------------------
package ptl_pkg;

  // default frame geometry
  localparam int unsigned TILE_COLUMNS = 16;
  localparam int unsigned PIXEL_ROWS   = 112;

  // stored bytes are the inverse of the raw bytes
  localparam logic [7:0] INV_MASK = 8'hFF;

  // saturation limit of the running pixel sum
  localparam logic [15:0] SUM_MAX = 16'hFFFF;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // store one raw byte
    logic fetch;  // read the two plane bytes of the next output item
    logic emit;   // build the result and advance the read position
  } cmd_t;

endpackage

/* sv/planar_tile_to_linear_pixels.sv */
// ----------------------------------------------------------------------------
// planar_tile_to_linear_pixels
// Loads a frame of 2bpp planar tile bytes and reads it back as packed
// row-major pixels, four per byte, with a saturating pixel sum per frame.
// ----------------------------------------------------------------------------
//  channel  | direction | fields
//  s_axis   | in        | tdata: raw_byte, tuser: func (0 load, 1 read)
//  m_axis   | out       | tdata: linear_byte, luma_sum; tlast: last_byte;
//           |           | tuser: not_ready
//
// a load item is stored as accepted and leaves the controller idle; a read
// item registers the low and high plane bytes, then fills the output register.
// reset clears the counters and the frame-loaded flag; the frame store is
// not cleared and holds no data until loaded, so no clearing pass runs.
// while a result waits in the output register further items still enter;
// a read stalls only until that register is free.
// ----------------------------------------------------------------------------
module planar_tile_to_linear_pixels #(
  parameter int unsigned TileColumns = ptl_pkg::TILE_COLUMNS,
  parameter int unsigned PixelRows   = ptl_pkg::PIXEL_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] raw_byte
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] linear_byte, [23:8] luma_sum
  output logic        m_axis_tlast,   // last_byte
  output logic        m_axis_tuser    // [0] not_ready
);

  ptl_pkg::cmd_t cmd;
  logic [7:0]    linear_byte;
  logic [15:0]   luma_sum;

  // handshake and sequencing
  ptl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_func_i   (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .cmd_o      (cmd)
  );

  // frame store and pixel datapath
  ptl_datapath #(
    .TileColumns (TileColumns),
    .PixelRows   (PixelRows)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .raw_byte_i    (s_axis_tdata),
    .linear_byte_o (linear_byte),
    .last_byte_o   (m_axis_tlast),
    .luma_sum_o    (luma_sum),
    .not_ready_o   (m_axis_tuser)
  );

  assign m_axis_tdata = {luma_sum, linear_byte};

endmodule

/* sv/ptl_ctrl.sv */
// ----------------------------------------------------------------------------
// ptl_ctrl
// Handshake controller: accepts items, sequences the frame store read and
// owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module ptl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  input  logic          s_func_i,
  output logic          s_tready_o,
  input  logic          m_tready_i,
  output logic          m_tvalid_o,
  output ptl_pkg::cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRead = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic slot_free;

  // item handshake
  assign s_tready_o = (state_q == StIdle);
  assign accept     = s_tvalid_i & s_tready_o;
  assign slot_free  = ~out_valid_q | m_tready_i;

  // commands
  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = accept & ~s_func_i;
    cmd_o.fetch = accept & s_func_i;
    cmd_o.emit  = (state_q == StRead) & slot_free;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.fetch) state_d = StRead;
      end
      StRead: begin
        if (slot_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_tvalid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* sv/ptl_datapath.sv */
// ----------------------------------------------------------------------------
// ptl_datapath
// Frame store, load and read position counters, pixel interleave and the
// saturating pixel sum, plus the output payload register.
// ----------------------------------------------------------------------------
module ptl_datapath #(
  parameter int unsigned TileColumns = ptl_pkg::TILE_COLUMNS,
  parameter int unsigned PixelRows   = ptl_pkg::PIXEL_ROWS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ptl_pkg::cmd_t cmd_i,
  input  logic [7:0]    raw_byte_i,
  output logic [7:0]    linear_byte_o,
  output logic          last_byte_o,
  output logic [15:0]   luma_sum_o,
  output logic          not_ready_o
);

  localparam int unsigned FrameBytes  = TileColumns * PixelRows * 2;
  localparam int unsigned BytesPerRow = TileColumns * 2;
  localparam int unsigned AddrSpan    = ((PixelRows + 7) / 8) * TileColumns * 16;
  localparam int unsigned AddrW       = $clog2(FrameBytes);
  localparam int unsigned CntW        = $clog2(FrameBytes + 1);
  localparam int unsigned SpanW       = $clog2(AddrSpan);
  localparam int unsigned ColW        = $clog2(BytesPerRow);
  localparam int unsigned RowW        = $clog2(PixelRows);

  logic [7:0]       mem [FrameBytes];

  logic [CntW-1:0]  load_cnt_q;
  logic             loaded_q;
  logic [RowW-1:0]  row_q;
  logic [ColW-1:0]  col_q;
  logic [15:0]      sum_q;

  logic [7:0]       lo_q, hi_q;
  logic             half_q, in_range_q, nr_q;

  logic [SpanW-1:0] band;
  logic [SpanW-1:0] tile_x;
  logic [SpanW-1:0] addr_lo;
  logic [SpanW-1:0] addr_hi;
  logic [CntW-1:0]  load_cnt_nxt;

  logic [3:0]       ln, hn;
  logic [7:0]       pix_byte;
  logic [2:0]       hi_cnt;
  logic [3:0]       byte_sum;
  logic [16:0]      sum_wide;
  logic [15:0]      sum_new;
  logic             is_last;

  // planar address of the next output item
  always_comb begin
    band    = SpanW'(row_q >> 3);
    tile_x  = SpanW'(col_q) >> 1;
    addr_lo = band * SpanW'(TileColumns * 16) + (tile_x << 4)
            + (SpanW'(row_q[2:0]) << 1);
    addr_hi = addr_lo | SpanW'(1);
  end

  // frame store write and dual registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem[loaded_q ? '0 : load_cnt_q[AddrW-1:0]] <= raw_byte_i ^ ptl_pkg::INV_MASK;
    end
    if (cmd_i.fetch) begin
      lo_q       <= mem[addr_lo[AddrW-1:0]];
      hi_q       <= mem[addr_hi[AddrW-1:0]];
      half_q     <= col_q[0];
      in_range_q <= ({1'b0, addr_lo} < (SpanW + 1)'(FrameBytes));
      nr_q       <= ~loaded_q;
    end
  end

  // pixel interleave, high plane gives bit 1
  always_comb begin
    ln = 4'd0;
    hn = 4'd0;
    if (in_range_q) begin
      ln = half_q ? lo_q[3:0] : lo_q[7:4];
      hn = half_q ? hi_q[3:0] : hi_q[7:4];
    end
    pix_byte = {hn[3], ln[3], hn[2], ln[2], hn[1], ln[1], hn[0], ln[0]};
    hi_cnt   = 3'(hn[0]) + 3'(hn[1]) + 3'(hn[2]) + 3'(hn[3]);
    byte_sum = {hi_cnt, 1'b0}
             + 4'(ln[0]) + 4'(ln[1]) + 4'(ln[2]) + 4'(ln[3]);
    sum_wide = {1'b0, sum_q} + 17'(byte_sum);
    sum_new  = sum_wide[16] ? ptl_pkg::SUM_MAX : sum_wide[15:0];
    is_last  = (row_q == RowW'(PixelRows - 1)) && (col_q == ColW'(BytesPerRow - 1));
  end

  assign load_cnt_nxt = loaded_q ? CntW'(1) : load_cnt_q + CntW'(1);

  // load and read position state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      loaded_q   <= 1'b0;
      row_q      <= '0;
      col_q      <= '0;
      sum_q      <= '0;
    end else begin
      if (cmd_i.load) begin
        load_cnt_q <= load_cnt_nxt;
        loaded_q   <= (load_cnt_nxt == CntW'(FrameBytes));
        if (loaded_q) begin
          row_q <= '0;
          col_q <= '0;
          sum_q <= '0;
        end
      end else if (cmd_i.emit && !nr_q) begin
        if (is_last) begin
          row_q <= '0;
          col_q <= '0;
          sum_q <= '0;
        end else begin
          sum_q <= sum_new;
          if (col_q == ColW'(BytesPerRow - 1)) begin
            col_q <= '0;
            row_q <= row_q + RowW'(1);
          end else begin
            col_q <= col_q + ColW'(1);
          end
        end
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (nr_q) begin
        linear_byte_o <= 8'd0;
        last_byte_o   <= 1'b0;
        luma_sum_o    <= 16'd0;
        not_ready_o   <= 1'b1;
      end else begin
        linear_byte_o <= pix_byte;
        last_byte_o   <= is_last;
        luma_sum_o    <= is_last ? sum_new : 16'd0;
        not_ready_o   <= 1'b0;
      end
    end
  end

endmodule

/* sim/tb_planar_tile_to_linear_pixels.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_planar_tile_to_linear_pixels
// Streams planar tile frames and readout requests into the converter under
// varying source gaps and sink stalls, predicts every output item from an
// in-bench frame model and compares the items field by field, in order.
// ----------------------------------------------------------------------------
module tb_planar_tile_to_linear_pixels;

  // small frame with a partial tile row keeps every frame cheap to load
  localparam int unsigned TILE_COLS   = 3;
  localparam int unsigned PIX_ROWS    = 12;
  localparam int unsigned ROW_BYTES   = TILE_COLS * 2;
  localparam int unsigned FRAME_BYTES = TILE_COLS * PIX_ROWS * 2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam int unsigned ITEMS_PER_PHASE = 255;
  localparam int unsigned DRAIN_CYCLES    = 10;

  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZEROS,
    FILL_ONES,
    FILL_CHECKER
  } fill_kind_e;

  typedef struct packed {
    logic       func;
    logic [7:0] raw;
  } tile_item_t;

  typedef struct packed {
    logic [7:0]  linear_byte;
    logic        last_byte;
    logic [15:0] luma_sum;
    logic        not_ready;
  } pixel_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // pending stimulus and expected output items
  tile_item_t  pending_items[$];
  pixel_out_t  expected_pixels[$];

  int unsigned send_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned error_count = 0;

  // shadow copy of the converter state
  logic [7:0]  shadow_frame [FRAME_BYTES];
  int unsigned shadow_load_cnt = 0;
  int unsigned shadow_read_cnt = 0;
  bit          shadow_loaded = 1'b0;
  int unsigned shadow_sum = 0;

  planar_tile_to_linear_pixels #(
    .TileColumns(TILE_COLS),
    .PixelRows  (PIX_ROWS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),    // [7:0] raw_byte
    .s_axis_tuser (s_axis_tuser),    // [0] func
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),    // [7:0] linear_byte, [23:8] luma_sum
    .m_axis_tlast (m_axis_tlast),    // last_byte
    .m_axis_tuser (m_axis_tuser)     // [0] not_ready
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // plane byte lookup, addresses past the frame read as zero
  function automatic logic [7:0] plane_byte(int unsigned addr);
    if (addr < FRAME_BYTES) begin
      return shadow_frame[addr];
    end
    return 8'h00;
  endfunction

  // updates the shadow state for one item, returns 1 when it yields an output
  function automatic bit predict_pixels(input tile_item_t item, output pixel_out_t res);
    int unsigned row, col, line, addr, shift;
    logic [3:0]  lo_nib, hi_nib;
    logic [1:0]  pix;
    logic [7:0]  packed_px;
    res = '0;
    if (item.func == FUNC_LOAD) begin
      if (shadow_loaded) begin
        shadow_loaded   = 1'b0;
        shadow_load_cnt = 0;
        shadow_read_cnt = 0;
        shadow_sum      = 0;
      end
      if (shadow_load_cnt < FRAME_BYTES) begin
        shadow_frame[shadow_load_cnt] = item.raw ^ ptl_pkg::INV_MASK;
        shadow_load_cnt++;
      end
      if (shadow_load_cnt >= FRAME_BYTES) begin
        shadow_loaded = 1'b1;
      end
      return 1'b0;
    end
    if (!shadow_loaded) begin
      res.not_ready = 1'b1;
      return 1'b1;
    end
    // locate the two plane bytes of this output item
    row    = shadow_read_cnt / ROW_BYTES;
    col    = shadow_read_cnt % ROW_BYTES;
    line   = (row >> 3) * TILE_COLS * 8 + (col >> 1) * 8 + (row & 7);
    addr   = line << 1;
    shift  = (col & 1) ? 0 : 4;
    lo_nib = 4'(plane_byte(addr) >> shift);
    hi_nib = 4'(plane_byte(addr + 1) >> shift);
    packed_px = '0;
    for (int k = 3; k >= 0; k--) begin
      pix = {hi_nib[k], lo_nib[k]};
      packed_px = {packed_px[5:0], pix};
      shadow_sum += pix;
      if (shadow_sum > ptl_pkg::SUM_MAX) begin
        shadow_sum = ptl_pkg::SUM_MAX;
      end
    end
    res.linear_byte = packed_px;
    if (shadow_read_cnt + 1 >= FRAME_BYTES) begin
      res.last_byte   = 1'b1;
      res.luma_sum    = shadow_sum[15:0];
      shadow_read_cnt = 0;
      shadow_sum      = 0;
    end else begin
      shadow_read_cnt++;
    end
    return 1'b1;
  endfunction

  // source side: predict on acceptance, then present the next item or idle
  always @(posedge clk_i or negedge rst_ni) begin : source_drv
    tile_item_t accepted, next_item;
    pixel_out_t res;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        accepted.func = s_axis_tuser;
        accepted.raw  = s_axis_tdata;
        if (predict_pixels(accepted, res)) begin
          expected_pixels.push_back(res);
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= next_item.raw;
          s_axis_tuser  <= next_item.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // output checker
  always @(posedge clk_i) begin : pixel_mon
    pixel_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected output item: tdata %0h tlast %0b tuser %0b",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tdata[7:0] !== want.linear_byte) begin
          $error("linear_byte mismatch: expected %0h, actual %0h",
                 want.linear_byte, m_axis_tdata[7:0]);
          error_count++;
        end
        if (m_axis_tlast !== want.last_byte) begin
          $error("last_byte mismatch: expected %0b, actual %0b",
                 want.last_byte, m_axis_tlast);
          error_count++;
        end
        if (m_axis_tdata[23:8] !== want.luma_sum) begin
          $error("luma_sum mismatch: expected %0d, actual %0d",
                 want.luma_sum, m_axis_tdata[23:8]);
          error_count++;
        end
        if (m_axis_tuser !== want.not_ready) begin
          $error("not_ready mismatch: expected %0b, actual %0b",
                 want.not_ready, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  task automatic queue_item(logic func, logic [7:0] raw);
    tile_item_t item;
    item.func = func;
    item.raw  = raw;
    pending_items.push_back(item);
  endtask

  // loads one whole frame, then reads part of it, all of it or past its end
  task automatic queue_frame_run(ref int unsigned queued);
    fill_kind_e  fill;
    logic [7:0]  raw;
    int unsigned n_reads;
    int unsigned read_mode;
    fill = fill_kind_e'($urandom_range(3));
    for (int unsigned i = 0; i < FRAME_BYTES; i++) begin
      case (fill)
        FILL_ZEROS:   raw = 8'h00;
        FILL_ONES:    raw = 8'hFF;
        FILL_CHECKER: raw = i[0] ? 8'hAA : 8'h55;
        default:      raw = 8'($urandom_range(255));
      endcase
      queue_item(FUNC_LOAD, raw);
    end
    read_mode = $urandom_range(3);
    case (read_mode)
      0:       n_reads = $urandom_range(1, 10);
      1:       n_reads = FRAME_BYTES;
      2:       n_reads = FRAME_BYTES + $urandom_range(1, FRAME_BYTES);
      default: n_reads = $urandom_range(FRAME_BYTES / 2, FRAME_BYTES - 1);
    endcase
    for (int unsigned i = 0; i < n_reads; i++) begin
      queue_item(FUNC_READ, 8'($urandom_range(255)));
    end
    queued += FRAME_BYTES + n_reads;
    // cut into the readout with a fresh partial frame
    if (read_mode == 3) begin
      for (int unsigned i = 0; i < 4; i++) begin
        queue_item(FUNC_LOAD, 8'($urandom_range(255)));
        queue_item(FUNC_READ, 8'($urandom_range(255)));
      end
      queued += 8;
    end
  endtask

  // runs one traffic phase and waits until it has fully drained
  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned queued;
    queued = 0;
    @(negedge clk_i);
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    while (queued < ITEMS_PER_PHASE) begin
      if ($urandom_range(9) < 8) begin
        queue_frame_run(queued);
      end else begin
        for (int unsigned i = 0; i < 12; i++) begin
          queue_item(1'($urandom_range(1)), 8'($urandom_range(255)));
        end
        queued += 12;
      end
    end
    while (pending_items.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // main sequence
  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reads before any load, plane extremes, reads mid-load
    queue_item(FUNC_READ, 8'h00);
    queue_item(FUNC_READ, 8'hFF);
    queue_item(FUNC_LOAD, 8'h00);
    queue_item(FUNC_LOAD, 8'hFF);
    queue_item(FUNC_READ, 8'h5A);
    queue_item(FUNC_LOAD, 8'h80);
    queue_item(FUNC_LOAD, 8'h78);
    queue_item(FUNC_LOAD, 8'h01);
    queue_item(FUNC_LOAD, 8'hFE);
    queue_item(FUNC_READ, 8'hA5);
    queue_item(FUNC_LOAD, 8'h55);
    queue_item(FUNC_LOAD, 8'hAA);
    queue_item(FUNC_READ, 8'h00);

    // no gaps, slow source, slow sink, then both
    run_phase(0, 0);
    run_phase(79, 0);
    run_phase(0, 79);
    run_phase(19, 19);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
sv/ptl_pkg.sv
sv/ptl_ctrl.sv
sv/ptl_datapath.sv
sv/planar_tile_to_linear_pixels.sv
sim/tb_planar_tile_to_linear_pixels.sv
